FILE: rtl/core/iotm_pkg.sv
// Package of the I/O throughput meter: types, codes and constants.
package iotm_pkg;

  localparam int unsigned RateFracBitsDef = 16;
  localparam logic [15:0] IntervalReset   = 16'd3;

  typedef enum logic [3:0] {
    FnReadBytes  = 4'd0,
    FnReadMsg    = 4'd1,
    FnWriteBytes = 4'd2,
    FnWriteMsg   = 4'd3,
    FnSchedBytes = 4'd4,
    FnSchedInc   = 4'd5,
    FnSchedDec   = 4'd6,
    FnUpdate     = 4'd7,
    FnQuery      = 4'd8,
    FnSetRead    = 4'd9,
    FnSetTime    = 4'd10
  } func_e;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StDiv,
    StStore,
    StOut
  } state_e;

  // Divider handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] delta;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] rate;
  } div_rsp_t;

endpackage

FILE: rtl/core/iotm_rate_div.sv
// Shared bit-serial divider: floor(delta * 1000 * 2^F / d), saturated.
module iotm_rate_div #(
  parameter int unsigned RateFracBits = iotm_pkg::RateFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iotm_pkg::div_req_t req_i,
  output iotm_pkg::div_rsp_t rsp_o
);
  import iotm_pkg::*;

  // The dividend is delta*1000 shifted left by the fraction bits.
  localparam int unsigned NumW = 64 + 10 + RateFracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [31:0]     rem_q, rem_d;
  logic [31:0]     den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            zero_q, zero_d;
  logic [73:0]     prod;
  logic [32:0]     trial;

  // delta * 1000 as delta * 1024 - delta * 16 - delta * 8.
  assign prod  = ({10'd0, req_i.delta} << 10) - ({10'd0, req_i.delta} << 4)
               - ({10'd0, req_i.delta} << 3);
  assign trial = {rem_q, num_q[NumW-1]};

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    zero_d = zero_q;
    rsp_o.done = 1'b0;
    rsp_o.rate = '0;
    if (req_i.start) begin
      num_d  = NumW'(prod) << RateFracBits;
      quo_d  = '0;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
      zero_d = (req_i.delta == 64'd0) || req_i.delta[63];
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d     = 1'b0;
        rsp_o.done = 1'b1;
        if (zero_q) begin
          rsp_o.rate = '0;
        end else if (|quo_q[NumW-1:64]) begin
          rsp_o.rate = '1;
        end else begin
          rsp_o.rate = quo_q[63:0];
        end
      end else begin
        num_d = {num_q[NumW-2:0], 1'b0};
        if (trial >= {1'b0, den_q}) begin
          rem_d = 32'(trial - {1'b0, den_q});
          quo_d = {quo_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = trial[31:0];
          quo_d = {quo_q[NumW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    zero_q <= zero_d;
  end

endmodule

FILE: rtl/core/io_throughput_meter.sv
// Top level of the I/O throughput meter: counters, sequencer and result register.
//
// Input beats arrive on s_axis: tdata packs amount[31:0], time_ms[94:32],
// stat_index[99:95] and active_sessions[115:100]; tuser carries func.
// Every input beat yields one output beat on m_axis: tdata holds stat_value
// and tuser holds rates_updated.
// A counter event, setter or query executes when its beat is accepted; the result
// then sits in the output register. An update that is not due first passes through
// a check of the elapsed time. The block takes one beat at a time
// and is not ready again until its result beat has been taken.
// An update that is due runs the shared bit-serial divider once for each of the
// four rates, in lane order: a start state (StDiv), then a wait in StStore until
// the divider is done, when the rate, peak and snapshot of that lane are stored.
// The interval register is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, the block itself does not enforce this.
// Reset clears all counters, times and rates and sets the interval to three
// seconds. When the receiver stalls, the result holds on m_axis and no new
// input beat is taken.
module io_throughput_meter #(
  parameter int unsigned RateFracBits = iotm_pkg::RateFracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // amount, time_ms, stat_index, active_sessions
  input  logic [3:0]   s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // stat_value
  output logic         m_axis_tuser,  // rates_updated
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);
  import iotm_pkg::*;

  state_e state_q, state_d;
  logic [63:0] tot_q [4];
  logic [63:0] snap_q [4];
  logic [63:0] cur_q [4];
  logic [63:0] peak_q [4];
  logic [62:0] rd_time_q, wr_time_q, calc_time_q, now_q;
  logic [31:0] sched_b_q, sched_m_q, elapsed_q;
  logic [15:0] interval_q;
  logic [1:0]  lane_q;
  logic [63:0] val_q;
  logic        upd_q;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        acc;

  logic [31:0] amt;
  logic [62:0] now;
  logic [4:0]  idx;
  logic [15:0] sess;
  logic [3:0]  fn;
  logic [63:0] amt_x;
  logic [31:0] min_ms;
  logic [31:0] elapsed;
  logic [1:0]  qlane;

  assign amt   = s_axis_tdata[31:0];
  assign now   = s_axis_tdata[94:32];
  assign idx   = s_axis_tdata[99:95];
  assign sess  = s_axis_tdata[115:100];
  assign fn    = s_axis_tuser;
  assign amt_x = {{32{amt[31]}}, amt};
  assign qlane = idx[1:0];
  assign min_ms  = {16'd0, interval_q} * 32'd1000;
  assign elapsed = now_q[31:0] - calc_time_q[31:0];

  assign s_axis_tready = (state_q == StIdle);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = val_q;
  assign m_axis_tuser  = upd_q;

  iotm_rate_div #(.RateFracBits(RateFracBits)) u_div (
    .clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp)
  );

  always_comb begin
    state_d = state_q;
    dreq.start   = 1'b0;
    dreq.delta   = tot_q[lane_q] - snap_q[lane_q];
    dreq.divisor = elapsed_q;
    case (state_q)
      StIdle:  if (acc) state_d = (func_e'(fn) == FnUpdate) ? StCheck : StOut;
      StCheck: begin
        if (min_ms == 32'd0 || elapsed[31] || elapsed < min_ms) begin
          state_d = StOut;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv:   begin
        dreq.start = 1'b1;
        state_d    = StStore;
      end
      StStore: if (drsp.done) state_d = (lane_q == 2'd3) ? StOut : StDiv;
      StOut:   if (m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      interval_q  <= IntervalReset;
      rd_time_q   <= '0;
      wr_time_q   <= '0;
      calc_time_q <= '0;
      sched_b_q   <= '0;
      sched_m_q   <= '0;
      lane_q      <= '0;
      upd_q       <= 1'b0;
      val_q       <= '0;
      now_q       <= '0;
      elapsed_q   <= '0;
      for (int i = 0; i < 4; i++) begin
        tot_q[i]  <= '0;
        snap_q[i] <= '0;
        cur_q[i]  <= '0;
        peak_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) interval_q <= cfg_wdata_i;
      case (state_q)
        StIdle: if (acc) begin
          val_q  <= '0;
          upd_q  <= 1'b0;
          now_q  <= now;
          lane_q <= '0;
          case (func_e'(fn))
            FnReadBytes:  begin tot_q[0] <= tot_q[0] + amt_x; rd_time_q <= now; end
            FnReadMsg:    begin tot_q[2] <= tot_q[2] + 64'd1; rd_time_q <= now; end
            FnWriteBytes: begin tot_q[1] <= tot_q[1] + amt_x; wr_time_q <= now; end
            FnWriteMsg:   begin tot_q[3] <= tot_q[3] + 64'd1; wr_time_q <= now; end
            FnSchedBytes: sched_b_q <= sched_b_q + amt;
            FnSchedInc:   sched_m_q <= sched_m_q + 32'd1;
            FnSchedDec:   sched_m_q <= sched_m_q - 32'd1;
            FnSetRead:    rd_time_q <= now;
            FnSetTime: begin
              if (idx == 5'd0) wr_time_q <= now;
              else if (idx == 5'd1) calc_time_q <= now;
            end
            FnQuery: begin
              if (idx < 5'd4) begin
                val_q <= tot_q[qlane];
              end else if (idx < 5'd8) begin
                // A rate query with no active session clears all current rates.
                if (sess == 16'd0) begin
                  for (int i = 0; i < 4; i++) cur_q[i] <= '0;
                  val_q <= '0;
                end else begin
                  val_q <= cur_q[qlane];
                end
              end else if (idx < 5'd12) begin
                val_q <= peak_q[qlane];
              end else begin
                case (idx)
                  5'd12:   val_q <= {1'b0, rd_time_q};
                  5'd13:   val_q <= {1'b0, wr_time_q};
                  5'd14:   val_q <= {1'b0, (rd_time_q > wr_time_q) ? rd_time_q : wr_time_q};
                  5'd15:   val_q <= {{32{sched_b_q[31]}}, sched_b_q};
                  5'd16:   val_q <= {{32{sched_m_q[31]}}, sched_m_q};
                  5'd17:   val_q <= {48'd0, interval_q};
                  default: val_q <= '0;
                endcase
              end
            end
            default: ;
          endcase
        end
        StCheck: elapsed_q <= elapsed;
        StStore: if (drsp.done) begin
          cur_q[lane_q]  <= drsp.rate;
          if (drsp.rate > peak_q[lane_q]) peak_q[lane_q] <= drsp.rate;
          snap_q[lane_q] <= tot_q[lane_q];
          lane_q         <= lane_q + 2'd1;
          if (lane_q == 2'd3) begin
            upd_q       <= 1'b1;
            calc_time_q <= now_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
